// ===== design/cpu6502_execute_unit_defines.svh =====
// Assertion macros used by the checker file of the execute unit.
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH

// Concurrent assertion on the rising clock, quiet while reset is applied.
`define C65_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define C65_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cpu65_pkg.sv =====
// Package with the word types, operation codes and constants of the execute unit.
`default_nettype none
package cpu65_pkg;
	localparam int STACK_DEPTH = 256;

	localparam logic [5:0] OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3;
	localparam logic [5:0] OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7;
	localparam logic [5:0] OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11;
	localparam logic [5:0] OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15;
	localparam logic [5:0] OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19;
	localparam logic [5:0] OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23;
	localparam logic [5:0] OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27;
	localparam logic [5:0] OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31;
	localparam logic [5:0] OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35;
	localparam logic [5:0] OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39;
	localparam logic [5:0] OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43;
	localparam logic [5:0] OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47;
	localparam logic [5:0] OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51;
	localparam logic [5:0] OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55;
	localparam logic [5:0] OP_LAX = 6'd56, OP_SAX = 6'd57, OP_ISBC = 6'd58;

	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_B = 4;
	localparam int FL_R = 5;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	localparam logic [1:0] CFG_DECIMAL = 2'd0;
	localparam logic [1:0] CFG_IRQ_VEC = 2'd1;
	localparam logic [1:0] CFG_NMI_VEC = 2'd2;

	localparam logic [7:0]  SP_RESET = 8'hFD;
	localparam logic [7:0]  P_RESET = 8'h24;
	localparam logic [15:0] IRQ_VEC_RESET = 16'hFFFE;
	localparam logic [15:0] NMI_VEC_RESET = 16'hFFFA;

	typedef struct packed {
		logic [5:0]  operation;
		logic        acc_mode;
		logic [7:0]  operand;
		logic [15:0] eff_address;
		logic [1:0]  instr_length;
		logic        irq_pending;
		logic        nmi_pending;
	} in_t;

	typedef struct packed {
		logic        mem_write;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [15:0] next_pc;
		logic [7:0]  acc_out;
		logic [7:0]  index_x_out;
		logic [7:0]  index_y_out;
		logic [7:0]  stack_ptr_out;
		logic [7:0]  status_out;
		logic        extra_cycle;
	} out_t;

	typedef struct packed {
		in_t        instr;
		logic [1:0] n_push;
		logic [1:0] n_pull;
	} dec_t;
endpackage
`default_nettype wire

// ===== design/cpu65_front.sv =====
// Front part: classifies each instruction word by its stack traffic.
`default_nettype none
module cpu65_front (
	input  wire cpu65_pkg::in_t  instr,
	output cpu65_pkg::dec_t      dec
);
	always_comb begin
		dec.instr = instr;
		dec.n_push = 2'd0;
		dec.n_pull = 2'd0;
		case (instr.operation)
			cpu65_pkg::OP_BRK: begin
				dec.n_push = 2'd3;
			end
			cpu65_pkg::OP_JSR: begin
				dec.n_push = 2'd2;
			end
			cpu65_pkg::OP_PHA, cpu65_pkg::OP_PHP: begin
				dec.n_push = 2'd1;
			end
			cpu65_pkg::OP_RTI: begin
				dec.n_pull = 2'd3;
			end
			cpu65_pkg::OP_RTS: begin
				dec.n_pull = 2'd2;
			end
			cpu65_pkg::OP_PLA, cpu65_pkg::OP_PLP: begin
				dec.n_pull = 2'd1;
			end
			default: begin
				dec.n_push = 2'd0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== design/cpu65_fifo.sv =====
// Two-entry queue of classified instructions between the front and back parts.
`default_nettype none
module cpu65_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire cpu65_pkg::dec_t  push_data,
	output logic                  full,
	output logic                  head_valid,
	output cpu65_pkg::dec_t       head,
	input  wire                   pop
);
	cpu65_pkg::dec_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== design/cpu65_back.sv =====
// Back part: register file, stack page store, ALU and result register.
`default_nettype none
module cpu65_back #(
	parameter int STACK_DEPTH = cpu65_pkg::STACK_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   head_valid,
	input  wire cpu65_pkg::dec_t  head,
	output logic                  pop,
	input  wire                   decimal_enable,
	input  wire [15:0]            irq_vector,
	input  wire [15:0]            nmi_vector,
	output logic                  result_valid,
	input  wire                   result_stall,
	output cpu65_pkg::out_t       result
);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
	logic [15:0] pc_q;
	logic [1:0]  step_q;
	logic [7:0]  pull0_q, pull1_q, rd_q;
	logic [7:0]  stack_mem [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] vld_q;
	cpu65_pkg::out_t out_q;
	logic        out_valid_q;

	cpu65_pkg::in_t it;
	logic [1:0]  last_idx;
	logic        fire, do_wr, do_rd;
	logic [7:0]  waddr8, raddr8, wbyte;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]  pb0, pb1, pb2;
	logic        intr;
	logic [15:0] ret;
	cpu65_pkg::out_t res;
	logic [7:0]  na, nx, ny, nsp, np, v, m, sh;
	logic [15:0] npc;
	logic        wr, taken, c_in;
	logic [9:0]  at;
	logic [10:0] st;
	logic [4:0]  lo_sum;
	logic signed [5:0] lo_diff;
	logic [8:0]  cd;

	assign it = head.instr;
	assign last_idx = (head.n_pull > ((head.n_push == 2'd0) ? 2'd0 : head.n_push - 2'd1))
		? head.n_pull : ((head.n_push == 2'd0) ? 2'd0 : head.n_push - 2'd1);
	assign fire = head_valid && (step_q == last_idx) && (!out_valid_q || !result_stall);
	assign pop = fire;
	assign do_wr = head_valid && (step_q < head.n_push);
	assign do_rd = head_valid && (step_q < head.n_pull);
	assign waddr8 = sp_q - {6'd0, step_q};
	assign raddr8 = sp_q + 8'd1 + {6'd0, step_q};
	assign waddr = waddr8[AW-1:0];
	assign raddr = raddr8[AW-1:0];

	assign intr = it.irq_pending || it.nmi_pending;
	assign ret = pc_q + ((it.operation == cpu65_pkg::OP_BRK && intr) ? 16'd0 : 16'd2);

	always_comb begin
		wbyte = ret[15:8];
		case (it.operation)
			cpu65_pkg::OP_PHA: begin
				wbyte = a_q;
			end
			cpu65_pkg::OP_PHP: begin
				wbyte = p_q | 8'h10;
			end
			default: begin
				case (step_q)
					2'd0: wbyte = ret[15:8];
					2'd1: wbyte = ret[7:0];
					default: wbyte = intr ? p_q : (p_q | 8'h10);
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			stack_mem[waddr] <= wbyte;
		end
		if (do_rd) begin
			rd_q <= vld_q[raddr] ? stack_mem[raddr] : 8'd0;
		end
		if (head_valid && step_q == 2'd1) begin
			pull0_q <= rd_q;
		end
		if (head_valid && step_q == 2'd2) begin
			pull1_q <= rd_q;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	assign pb0 = (step_q == 2'd1) ? rd_q : pull0_q;
	assign pb1 = (step_q == 2'd2) ? rd_q : pull1_q;
	assign pb2 = rd_q;

	always_comb begin
		m = it.operand;
		na = a_q;
		nx = x_q;
		ny = y_q;
		np = p_q;
		nsp = sp_q - {6'd0, head.n_push} + {6'd0, head.n_pull};
		npc = pc_q + {14'd0, it.instr_length};
		wr = 1'b0;
		v = 8'd0;
		taken = 1'b0;
		c_in = p_q[cpu65_pkg::FL_C];
		sh = it.acc_mode ? a_q : m;
		at = 10'd0;
		st = 11'd0;
		lo_sum = 5'd0;
		lo_diff = 6'sd0;
		cd = 9'd0;
		case (it.operation)
			cpu65_pkg::OP_ADC: begin
				at = {2'b0, a_q} + {2'b0, m} + {9'd0, c_in};
				np[cpu65_pkg::FL_Z] = (at[7:0] == 8'd0);
				lo_sum = {1'b0, a_q[3:0]} + {1'b0, m[3:0]} + {4'd0, c_in};
				if (decimal_enable && p_q[cpu65_pkg::FL_D]) begin
					if (lo_sum > 5'd9) begin
						at = at + 10'd6;
					end
					np[cpu65_pkg::FL_N] = at[7];
					np[cpu65_pkg::FL_V] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ at[7]);
					if (at > 10'h99) begin
						at = at + 10'd96;
					end
					np[cpu65_pkg::FL_C] = (at > 10'h99);
				end else begin
					np[cpu65_pkg::FL_N] = at[7];
					np[cpu65_pkg::FL_V] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ at[7]);
					np[cpu65_pkg::FL_C] = at[8];
				end
				na = at[7:0];
			end
			cpu65_pkg::OP_SBC, cpu65_pkg::OP_ISBC: begin
				st = {3'b0, a_q} - {3'b0, m} - {10'd0, ~c_in};
				np[cpu65_pkg::FL_N] = st[7];
				np[cpu65_pkg::FL_Z] = (st[7:0] == 8'd0);
				np[cpu65_pkg::FL_V] = (a_q[7] ^ st[7]) & (a_q[7] ^ m[7]);
				if (it.operation == cpu65_pkg::OP_SBC && decimal_enable
					&& p_q[cpu65_pkg::FL_D]) begin
					lo_diff = $signed({2'b0, a_q[3:0]}) - $signed({5'b0, ~c_in});
					if (lo_diff < $signed({2'b0, m[3:0]})) begin
						st = st - 11'd6;
					end
					if (st[10] || st[9:0] > 10'h99) begin
						st = st - 11'h60;
					end
				end
				np[cpu65_pkg::FL_C] = ~st[10] && (st[9:8] == 2'b00);
				na = st[7:0];
			end
			cpu65_pkg::OP_AND: begin
				na = a_q & m;
				np[cpu65_pkg::FL_N] = na[7];
				np[cpu65_pkg::FL_Z] = (na == 8'd0);
			end
			cpu65_pkg::OP_ORA: begin
				na = a_q | m;
				np[cpu65_pkg::FL_N] = na[7];
				np[cpu65_pkg::FL_Z] = (na == 8'd0);
			end
			cpu65_pkg::OP_EOR: begin
				na = a_q ^ m;
				np[cpu65_pkg::FL_N] = na[7];
				np[cpu65_pkg::FL_Z] = (na == 8'd0);
			end
			cpu65_pkg::OP_ASL, cpu65_pkg::OP_LSR, cpu65_pkg::OP_ROL, cpu65_pkg::OP_ROR: begin
				case (it.operation)
					cpu65_pkg::OP_ASL: begin
						v = {sh[6:0], 1'b0};
						np[cpu65_pkg::FL_C] = sh[7];
					end
					cpu65_pkg::OP_ROL: begin
						v = {sh[6:0], c_in};
						np[cpu65_pkg::FL_C] = sh[7];
					end
					cpu65_pkg::OP_LSR: begin
						v = {1'b0, sh[7:1]};
						np[cpu65_pkg::FL_C] = sh[0];
					end
					default: begin
						v = {c_in, sh[7:1]};
						np[cpu65_pkg::FL_C] = sh[0];
					end
				endcase
				np[cpu65_pkg::FL_N] = v[7];
				np[cpu65_pkg::FL_Z] = (v == 8'd0);
				if (it.acc_mode) begin
					na = v;
				end else begin
					wr = 1'b1;
				end
			end
			cpu65_pkg::OP_BCC: taken = ~p_q[cpu65_pkg::FL_C];
			cpu65_pkg::OP_BCS: taken = p_q[cpu65_pkg::FL_C];
			cpu65_pkg::OP_BEQ: taken = p_q[cpu65_pkg::FL_Z];
			cpu65_pkg::OP_BNE: taken = ~p_q[cpu65_pkg::FL_Z];
			cpu65_pkg::OP_BMI: taken = p_q[cpu65_pkg::FL_N];
			cpu65_pkg::OP_BPL: taken = ~p_q[cpu65_pkg::FL_N];
			cpu65_pkg::OP_BVS: taken = p_q[cpu65_pkg::FL_V];
			cpu65_pkg::OP_BVC: taken = ~p_q[cpu65_pkg::FL_V];
			cpu65_pkg::OP_BIT: begin
				np[cpu65_pkg::FL_N] = m[7];
				np[cpu65_pkg::FL_V] = m[6];
				np[cpu65_pkg::FL_Z] = ((m & a_q) == 8'd0);
			end
			cpu65_pkg::OP_BRK: begin
				np[cpu65_pkg::FL_I] = 1'b1;
				npc = it.nmi_pending ? nmi_vector : irq_vector;
			end
			cpu65_pkg::OP_CLC: np[cpu65_pkg::FL_C] = 1'b0;
			cpu65_pkg::OP_CLD: np[cpu65_pkg::FL_D] = 1'b0;
			cpu65_pkg::OP_CLI: np[cpu65_pkg::FL_I] = 1'b0;
			cpu65_pkg::OP_CLV: np[cpu65_pkg::FL_V] = 1'b0;
			cpu65_pkg::OP_SEC: np[cpu65_pkg::FL_C] = 1'b1;
			cpu65_pkg::OP_SED: np[cpu65_pkg::FL_D] = 1'b1;
			cpu65_pkg::OP_SEI: np[cpu65_pkg::FL_I] = 1'b1;
			cpu65_pkg::OP_CMP, cpu65_pkg::OP_CPX, cpu65_pkg::OP_CPY: begin
				case (it.operation)
					cpu65_pkg::OP_CMP: cd = {1'b0, a_q} - {1'b0, m};
					cpu65_pkg::OP_CPX: cd = {1'b0, x_q} - {1'b0, m};
					default: cd = {1'b0, y_q} - {1'b0, m};
				endcase
				np[cpu65_pkg::FL_C] = ~cd[8];
				np[cpu65_pkg::FL_N] = cd[7];
				np[cpu65_pkg::FL_Z] = (cd == 9'd0);
			end
			cpu65_pkg::OP_DEC, cpu65_pkg::OP_INC: begin
				v = (it.operation == cpu65_pkg::OP_DEC) ? m - 8'd1 : m + 8'd1;
				np[cpu65_pkg::FL_N] = v[7];
				np[cpu65_pkg::FL_Z] = (v == 8'd0);
				wr = 1'b1;
			end
			cpu65_pkg::OP_DEX, cpu65_pkg::OP_INX, cpu65_pkg::OP_LDX, cpu65_pkg::OP_TAX,
			cpu65_pkg::OP_TSX: begin
				case (it.operation)
					cpu65_pkg::OP_DEX: nx = x_q - 8'd1;
					cpu65_pkg::OP_INX: nx = x_q + 8'd1;
					cpu65_pkg::OP_LDX: nx = m;
					cpu65_pkg::OP_TAX: nx = a_q;
					default: nx = sp_q;
				endcase
				np[cpu65_pkg::FL_N] = nx[7];
				np[cpu65_pkg::FL_Z] = (nx == 8'd0);
			end
			cpu65_pkg::OP_DEY, cpu65_pkg::OP_INY, cpu65_pkg::OP_LDY, cpu65_pkg::OP_TAY: begin
				case (it.operation)
					cpu65_pkg::OP_DEY: ny = y_q - 8'd1;
					cpu65_pkg::OP_INY: ny = y_q + 8'd1;
					cpu65_pkg::OP_LDY: ny = m;
					default: ny = a_q;
				endcase
				np[cpu65_pkg::FL_N] = ny[7];
				np[cpu65_pkg::FL_Z] = (ny == 8'd0);
			end
			cpu65_pkg::OP_LDA, cpu65_pkg::OP_TXA, cpu65_pkg::OP_TYA, cpu65_pkg::OP_PLA,
			cpu65_pkg::OP_LAX: begin
				case (it.operation)
					cpu65_pkg::OP_TXA: na = x_q;
					cpu65_pkg::OP_TYA: na = y_q;
					cpu65_pkg::OP_PLA: na = pb0;
					default: na = m;
				endcase
				if (it.operation == cpu65_pkg::OP_LAX) begin
					nx = m;
				end
				np[cpu65_pkg::FL_N] = na[7];
				np[cpu65_pkg::FL_Z] = (na == 8'd0);
			end
			cpu65_pkg::OP_JMP, cpu65_pkg::OP_JSR: npc = it.eff_address;
			cpu65_pkg::OP_PLP: np = (pb0 & 8'hEF) | 8'h20;
			cpu65_pkg::OP_RTI: begin
				np = pb0 | 8'h20;
				npc = {pb2, pb1};
			end
			cpu65_pkg::OP_RTS: npc = {pb1, pb0} + 16'd1;
			cpu65_pkg::OP_STA: begin
				wr = 1'b1;
				v = a_q;
			end
			cpu65_pkg::OP_STX: begin
				wr = 1'b1;
				v = x_q;
			end
			cpu65_pkg::OP_STY: begin
				wr = 1'b1;
				v = y_q;
			end
			cpu65_pkg::OP_SAX: begin
				wr = 1'b1;
				v = a_q & x_q;
			end
			cpu65_pkg::OP_TXS: nsp = x_q;
			default: begin
				wr = 1'b0;
			end
		endcase
		res.extra_cycle = 1'b0;
		if (taken) begin
			res.extra_cycle = (pc_q[15:8] != it.eff_address[15:8]);
			npc = it.eff_address + {14'd0, it.instr_length};
		end
		res.mem_write = wr;
		res.write_address = wr ? it.eff_address : 16'd0;
		res.write_data = wr ? v : 8'd0;
		res.next_pc = npc;
		res.acc_out = na;
		res.index_x_out = nx;
		res.index_y_out = ny;
		res.stack_ptr_out = nsp;
		res.status_out = np;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0;
			x_q <= 8'd0;
			y_q <= 8'd0;
			sp_q <= cpu65_pkg::SP_RESET;
			p_q <= cpu65_pkg::P_RESET;
			pc_q <= 16'd0;
			step_q <= 2'd0;
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_wr) begin
				vld_q[waddr] <= 1'b1;
			end
			if (fire) begin
				a_q <= res.acc_out;
				x_q <= res.index_x_out;
				y_q <= res.index_y_out;
				sp_q <= res.stack_ptr_out;
				p_q <= res.status_out;
				pc_q <= res.next_pc;
				step_q <= 2'd0;
				out_valid_q <= 1'b1;
			end else begin
				if (head_valid && step_q != last_idx) begin
					step_q <= step_q + 2'd1;
				end
				if (!result_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;
endmodule
`default_nettype wire

// ===== design/cpu6502_execute_unit.sv =====
// Top level of the 6502 execute unit: configuration registers and part wiring.
//  Channel   Direction  Handshake                  Word
//  instr     in         instr_valid / instr_stall  cpu65_pkg::in_t
//  result    out        result_valid / result_stall cpu65_pkg::out_t
//  cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
// PLA, PLP, JSR, RTS, BRK and RTI step through the stack store, which moves one byte per
// step; PHA, PHP and the other instructions do not wait on it in the back part.
// Reset sets the registers to their reset values and clears the valid bits of the stack page at once.
// A two-word queue takes in up to two input words while the result word is stalled.
`default_nettype none
module cpu6502_execute_unit #(
	parameter int STACK_DEPTH = cpu65_pkg::STACK_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   instr_valid,
	output logic                  instr_stall,
	input  wire cpu65_pkg::in_t   instr,
	output logic                  result_valid,
	input  wire                   result_stall,
	output cpu65_pkg::out_t       result,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [1:0]             cfg_index,
	input  wire [15:0]            cfg_data
);
	logic            decimal_q;
	logic [15:0]     irq_vec_q, nmi_vec_q;
	cpu65_pkg::dec_t dec, head;
	logic            full, head_valid, pop;

	assign cfg_ready = 1'b1;
	assign instr_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimal_q <= 1'b1;
			irq_vec_q <= cpu65_pkg::IRQ_VEC_RESET;
			nmi_vec_q <= cpu65_pkg::NMI_VEC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpu65_pkg::CFG_DECIMAL: decimal_q <= cfg_data[0];
				cpu65_pkg::CFG_IRQ_VEC: irq_vec_q <= cfg_data;
				cpu65_pkg::CFG_NMI_VEC: nmi_vec_q <= cfg_data;
				default: begin
					decimal_q <= decimal_q;
				end
			endcase
		end
	end

	cpu65_front u_front (
		.instr (instr),
		.dec   (dec)
	);

	cpu65_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (instr_valid && !full),
		.push_data  (dec),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	cpu65_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.decimal_enable (decimal_q),
		.irq_vector     (irq_vec_q),
		.nmi_vector     (nmi_vec_q),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result)
	);
endmodule
`default_nettype wire

// ===== design/cpu65_checker.sv =====
// Port checker for the execute unit, bound to the top level.
`default_nettype none
`include "cpu6502_execute_unit_defines.svh"
module cpu65_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  result_valid,
	input wire                  result_stall,
	input wire cpu65_pkg::out_t result
);
	`C65_ASSERT(a_hold, result_valid && result_stall |=> result_valid, "result word dropped")
	`C65_ASSERT(a_stable, result_valid && result_stall |=> $stable(result), "stalled word changed")
	`C65_ASSERT(a_nowrite, result_valid && !result.mem_write |-> result.write_address == 16'd0 && result.write_data == 8'd0, "idle write fields not zero")
	`C65_ASSERT_ALWAYS(a_rbit, result_valid |-> result.status_out[5], "status R bit clear")
endmodule

bind cpu6502_execute_unit cpu65_checker u_checker (.*);
`default_nettype wire
